// File: sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the Go-Back-N sender window block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  // Default sizing of the window and the sequence space.
  localparam int WINDOW_DEPTH_DEF = 8;
  localparam int SEQ_BITS_DEF     = 8;

  // Reset value of the timeout register, in ticks.
  localparam logic [15:0] TIMEOUT_RESET = 16'd5;

  // Configuration port address width and register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0
  } reg_idx_t;

  // Command codes of the input word.
  typedef enum logic [1:0] {
    CMD_SEND   = 2'd0,
    CMD_ACK    = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_code_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_SENT      = 3'd0,
    KIND_RESENT    = 3'd1,
    KIND_REFUSED   = 3'd2,
    KIND_ACK_OK    = 3'd3,
    KIND_ACK_OUT   = 3'd4,
    KIND_TICK_NONE = 3'd5
  } kind_t;

  // Input word.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] ack_seq;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] seq_num;
    logic [7:0] window_base;
    logic [3:0] outstanding;
    logic       last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  do_send;
    logic  do_ack;
    logic  do_tick;
    logic  rs_start;
    logic  rs_step;
    logic  emit;
    kind_t kind;
    logic  last;
  } gbn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_code_t cmd;
    logic      full;
    logic      ack_in_win;
    logic      timeout;
    logic      rs_last;
  } gbn_sts_t;

endpackage

`default_nettype wire

// File: sv/gbn_regs.sv
// ----------------------------------------------------------------------------
// gbn_regs
// APB-style configuration register file holding the acknowledgement timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_regs
  import gbn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [15:0]           timeout
);

  logic [15:0] timeout_r;
  logic [15:0] timeout_nxt;
  logic        wr_en;
  reg_idx_t    reg_idx;

  // Registers sit on 32-bit boundaries.
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Next value of the timeout register.
  always_comb begin
    timeout_nxt = timeout_r;
    if (wr_en && reg_idx == REG_TIMEOUT) begin
      timeout_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT: prdata = {{(CFG_DATA_W-16){1'b0}}, timeout_r};
      default:     prdata = '0;
    endcase
  end

  assign timeout = timeout_r;

endmodule

`default_nettype wire

// File: sv/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Controller state machine: accepts commands, decides the outcome from the
// datapath status, and walks the window on a timeout resend.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_ctrl
  import gbn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire gbn_sts_t sts,
  output gbn_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESEND
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign busy = (state_r != ST_IDLE);

  // Decode the current command into datapath actions.
  always_comb begin
    cmd       = '0;
    cmd.kind  = KIND_TICK_NONE;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        cmd.emit  = 1'b1;
        cmd.last  = 1'b1;
        unique case (sts.cmd)
          CMD_SEND: begin
            if (sts.full) begin
              cmd.kind = KIND_REFUSED;
            end else begin
              cmd.do_send = 1'b1;
              cmd.kind    = KIND_SENT;
            end
          end
          CMD_ACK: begin
            if (sts.ack_in_win) begin
              cmd.do_ack = 1'b1;
              cmd.kind   = KIND_ACK_OK;
            end else begin
              cmd.kind = KIND_ACK_OUT;
            end
          end
          CMD_TICK: begin
            cmd.do_tick = 1'b1;
            if (sts.timeout) begin
              cmd.emit     = 1'b0;
              cmd.last     = 1'b0;
              cmd.rs_start = 1'b1;
              state_nxt    = ST_RESEND;
            end
          end
          default: begin
            cmd.kind = KIND_TICK_NONE;
          end
        endcase
      end
      ST_RESEND: begin
        cmd.rs_step = 1'b1;
        cmd.emit    = 1'b1;
        cmd.kind    = KIND_RESENT;
        cmd.last    = sts.rs_last;
        if (sts.rs_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/gbn_dpath.sv
// ----------------------------------------------------------------------------
// gbn_dpath
// Datapath: window base, outstanding count, tick counter, circular store of
// send stamps and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_dpath
  import gbn_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SEQ_BITS     = SEQ_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_word_t    in_word,
  input  wire logic [15:0] timeout,
  input  wire gbn_cmd_t    cmd,
  output gbn_sts_t         sts,
  output logic             out_valid,
  output out_word_t        out_word
);

  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SB = SEQ_BITS;

  // Stamp store, oldest entry at the head pointer.
  logic [31:0]   stamp_mem [WINDOW_DEPTH];
  logic [31:0]   stamp_rd_r;

  logic [SB-1:0] base_r,   base_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic [IW-1:0] head_r,   head_nxt;
  logic [31:0]   tick_r,   tick_nxt;
  cmd_code_t     cmd_r;
  logic [SB-1:0] ack_r;
  logic [CW-1:0] rs_idx_r, rs_idx_nxt;
  logic [IW-1:0] rs_ptr_r, rs_ptr_nxt;
  logic          out_valid_r;
  out_word_t     out_word_r, out_word_nxt;

  logic [SB-1:0] ack_dist;
  logic [CW-1:0] retire;
  logic [IW:0]   head_sum;
  logic [IW:0]   tail_sum;
  logic [IW-1:0] tail_ptr;
  logic [31:0]   tick_inc;
  logic [31:0]   elapsed;
  logic [SB-1:0] seq_out;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;

  // Status toward the controller.
  assign ack_dist = ack_r - base_r;
  assign tick_inc = tick_r + 32'd1;
  assign elapsed  = tick_inc - stamp_rd_r;

  assign sts.cmd        = cmd_r;
  assign sts.full       = (cnt_r == CW'(WINDOW_DEPTH));
  assign sts.ack_in_win = (32'(ack_dist) < 32'(cnt_r));
  assign sts.timeout    = (cnt_r != '0) && (elapsed >= 32'(timeout));
  assign sts.rs_last    = (rs_idx_r == cnt_r - CW'(1));

  // Slot of the next new entry: head plus count, wrapped once.
  assign tail_sum = (IW+1)'(head_r) + (IW+1)'(cnt_r);
  assign tail_ptr = (tail_sum >= (IW+1)'(WINDOW_DEPTH)) ?
                    IW'(tail_sum - (IW+1)'(WINDOW_DEPTH)) : IW'(tail_sum);

  // Retirement of a cumulative acknowledgement.
  assign retire   = CW'(ack_dist) + CW'(1);
  assign head_sum = (IW+1)'(head_r) + (IW+1)'(retire);

  // Window state update.
  always_comb begin
    base_nxt   = base_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    tick_nxt   = tick_r;
    rs_idx_nxt = rs_idx_r;
    rs_ptr_nxt = rs_ptr_r;
    seq_out    = '0;
    if (cmd.do_send) begin
      seq_out = SB'(32'(base_r) + 32'(cnt_r));
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.do_ack) begin
      cnt_nxt  = cnt_r - retire;
      base_nxt = base_r + SB'(retire);
      head_nxt = (head_sum >= (IW+1)'(WINDOW_DEPTH)) ?
                 IW'(head_sum - (IW+1)'(WINDOW_DEPTH)) : IW'(head_sum);
    end
    if (cmd.do_tick) begin
      tick_nxt = tick_inc;
    end
    if (cmd.rs_start) begin
      rs_idx_nxt = '0;
      rs_ptr_nxt = head_r;
    end
    if (cmd.rs_step) begin
      seq_out    = SB'(32'(base_r) + 32'(rs_idx_r));
      rs_idx_nxt = rs_idx_r + CW'(1);
      rs_ptr_nxt = (rs_ptr_r == IW'(WINDOW_DEPTH - 1)) ? '0 : rs_ptr_r + IW'(1);
    end
  end

  // Stamp store write port: new entry on a send, restamp on a resend.
  assign mem_we    = cmd.do_send || cmd.rs_step;
  assign mem_waddr = cmd.rs_step ? rs_ptr_r : tail_ptr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_waddr] <= tick_r;
    end
    stamp_rd_r <= stamp_mem[head_r];
  end

  // Result word, built from the state after this step.
  always_comb begin
    out_word_nxt             = out_word_r;
    if (cmd.emit) begin
      out_word_nxt.kind        = cmd.kind;
      out_word_nxt.seq_num     = 8'(seq_out);
      out_word_nxt.window_base = 8'(base_nxt);
      out_word_nxt.outstanding = 4'(cnt_nxt);
      out_word_nxt.last        = cmd.last;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= cmd_code_t'(in_word.command);
      ack_r <= SB'(in_word.ack_seq);
    end
    rs_idx_r   <= rs_idx_nxt;
    rs_ptr_r   <= rs_ptr_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// File: sv/go_back_n_sender_window.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N ARQ sender window control: sequence numbering, cumulative
// acknowledgements and timeout resend of the whole window.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Send, ack and
// unused commands, and a tick that does not time out, pass from acceptance
// through the execute state, after which the single result word is on out_word
// for one cycle with out_valid high, and a new command may be accepted in that
// same cycle. A tick that times out goes on to a resend state that covers every
// outstanding entry: the resend sequencer writes one fresh stamp to the stamp
// store and emits one resent word each cycle, the last one flagged. Results
// cannot be held off: the receiver must take every word in the cycle it appears.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_window
  import gbn_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SEQ_BITS     = SEQ_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Command channel.
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_word_t              in_word,
  // Result channel.
  output logic                       out_valid,
  output out_word_t                  out_word,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [15:0] timeout;
  gbn_cmd_t    cmd;
  gbn_sts_t    sts;

  // Configuration registers.
  gbn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .timeout (timeout)
  );

  // Controller.
  gbn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath.
  gbn_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SEQ_BITS     (SEQ_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .timeout   (timeout),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
